### sv/isotp_receive_reassembler_assert.svh
// ============================================================================
// ISO-TP receive reassembler assertion macros
// Shared property macros for the controller and the datapath.
// ============================================================================
`ifndef ISOTP_RECEIVE_REASSEMBLER_ASSERT_SVH
`define ISOTP_RECEIVE_REASSEMBLER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`ifndef SYNTH
`define ISOTP_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("isotp_receive_reassembler: assertion failed");
`else
`define ISOTP_ASSERT_IMPL(label, ante, cons)
`endif

// Next-cycle implication, checked on every rising clock edge out of reset.
`ifndef SYNTH
`define ISOTP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("isotp_receive_reassembler: assertion failed");
`else
`define ISOTP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### sv/isotp_pkg.sv
// ============================================================================
// ISO-TP receive reassembler package
// Widths, codes, payload structs and controller/datapath handshake types.
// ============================================================================
package isotp_pkg;

   // Configuration port geometry.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_ADDRESSING_MODE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_ADDRESS     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REMOTE_ADDRESS  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FULL_FRAME      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAD_BYTE        = 3'd4;

   // Input commands.
   localparam logic CMD_FRAME   = 1'b0;
   localparam logic CMD_TIMEOUT = 1'b1;

   // Result kinds.
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_FC    = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   // Error codes.
   localparam logic [2:0] ERR_TIMEOUT    = 3'd0;
   localparam logic [2:0] ERR_WRONG_ADDR = 3'd1;
   localparam logic [2:0] ERR_INVALID    = 3'd2;
   localparam logic [2:0] ERR_UNEXPECTED = 3'd3;
   localparam logic [2:0] ERR_BAD_LENGTH = 3'd4;

   // Protocol control nibbles.
   localparam logic [3:0] PCI_SINGLE      = 4'h0;
   localparam logic [3:0] PCI_FIRST       = 4'h1;
   localparam logic [3:0] PCI_CONSECUTIVE = 4'h2;

   // Flow control: continue to send, block size 0, separation time 0.
   localparam logic [7:0] FC_CTS      = 8'h30;
   localparam logic [3:0] FC_FULL_LEN = 4'd8;

   // What follows the payload bytes of one item.
   localparam logic [1:0] TAIL_NONE  = 2'd0;
   localparam logic [1:0] TAIL_DONE  = 2'd1;
   localparam logic [1:0] TAIL_FC    = 2'd2;
   localparam logic [1:0] TAIL_ERROR = 2'd3;

   typedef struct packed {
      logic       command;
      logic [3:0] frame_length;
      logic [7:0] frame_byte0;
      logic [7:0] frame_byte1;
      logic [7:0] frame_byte2;
      logic [7:0] frame_byte3;
      logic [7:0] frame_byte4;
      logic [7:0] frame_byte5;
      logic [7:0] frame_byte6;
      logic [7:0] frame_byte7;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic [3:0]  fc_length;
      logic [7:0]  fc_byte0;
      logic [7:0]  fc_byte1;
      logic [7:0]  fc_byte2;
      logic [7:0]  fc_byte3;
      logic [11:0] message_length;
      logic [2:0]  error_code;
      logic        last;
   } rsp_payload_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic emit_last;
   } sts_type;

endpackage

### sv/isotp_req_if.sv
// ============================================================================
// ISO-TP request channel
// Valid/ready channel that carries one received frame or timeout per item.
// ============================================================================
interface isotp_req_if;
   import isotp_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### sv/isotp_rsp_if.sv
// ============================================================================
// ISO-TP response channel
// Valid/ready channel that carries one reassembler result per item.
// ============================================================================
interface isotp_rsp_if;
   import isotp_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### sv/isotp_receive_reassembler.sv
// ============================================================================
// ISO-TP receive reassembler
// Reassembles ISO-TP messages from received CAN frames, normal or extended
// addressing, and reports payload bytes, flow control, completion and errors.
// ============================================================================
// A taken frame and its result plan are registered; its first result is then
// registered into the output register once that register is free. A frame yields
// 1 to 8 results and may arrive while the block is idle or with the previous
// frame's final result; the serial result emitter with its single output register
// gives one result per cycle while the output is not held by back-pressure.
// Reset: synchronous; clears reception state and loads register defaults.

module isotp_receive_reassembler (
   input  logic                              clock,
   input  logic                              reset,
   isotp_req_if.sink                         req_chan,
   isotp_rsp_if.source                       rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [isotp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [isotp_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import isotp_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer.
   isotp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Decode, state and result output.
   isotp_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_chan.payload),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_payload      (rsp_chan.payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

### sv/isotp_ctrl.sv
// ============================================================================
// ISO-TP reassembler controller
// Two-state sequencer: takes a frame, then steps the datapath through its
// results one per free output slot.
// ============================================================================
`include "isotp_receive_reassembler_assert.svh"

module isotp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  isotp_pkg::sts_type sts,
   output isotp_pkg::cmd_type cmd
);
   import isotp_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic state_ff;
   logic state_in;
   logic final_emit;

   // The last result of an item frees the block for the next frame.
   assign final_emit = (state_ff == ST_EMIT) && sts.out_free && sts.emit_last;
   assign req_ready  = (state_ff == ST_IDLE) || final_emit;
   assign cmd.load   = req_valid && req_ready;
   assign cmd.emit   = (state_ff == ST_EMIT) && sts.out_free;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (final_emit) begin
               state_in = cmd.load ? ST_EMIT : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Results are only produced while an item is in progress.
   `ISOTP_ASSERT_IMPL(a_emit_in_progress, cmd.emit, state_ff == ST_EMIT)
   // A frame taken mid-item only overlaps the final result of the previous one.
   `ISOTP_ASSERT_IMPL(a_overlap_on_final, cmd.load && (state_ff == ST_EMIT),
      cmd.emit && sts.emit_last)
   // Final result with no new frame returns to idle.
   `ISOTP_ASSERT_NEXT(a_final_to_idle, final_emit && !cmd.load, state_ff == ST_IDLE)

endmodule

### sv/isotp_dpath.sv
// ============================================================================
// ISO-TP reassembler datapath
// Configuration registers, frame decode, reception state, frame store and
// the registered result output.
// ============================================================================
`include "isotp_receive_reassembler_assert.svh"

module isotp_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  isotp_pkg::req_payload_type          req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output isotp_pkg::rsp_payload_type          rsp_payload,
   input  logic                                csr_write_enable,
   input  logic [isotp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [isotp_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  isotp_pkg::cmd_type                  cmd,
   output isotp_pkg::sts_type                  sts
);
   import isotp_pkg::*;

   typedef struct packed {
      logic        receiving;
      logic [11:0] expected_length;
      logic [11:0] received_count;
   } rx_state_type;

   typedef struct packed {
      logic [2:0]  nbytes;
      logic [2:0]  first;
      logic [1:0]  tail;
      logic [2:0]  error_code;
      logic [11:0] message_length;
   } plan_type;

   // Configuration registers.
   logic       cfg_mode_ff;
   logic [7:0] cfg_own_ff;
   logic [7:0] cfg_remote_ff;
   logic       cfg_full_ff;
   logic [7:0] cfg_pad_ff;

   rx_state_type rx_ff;
   rx_state_type rx_in;
   plan_type     plan_ff;
   plan_type     plan_in;
   logic [7:0]   frame_ff [8];
   logic [3:0]   idx_ff;

   logic            off;
   logic [7:0]      pci;
   logic            addr_bad;
   logic [3:0]      sf_len;
   logic [11:0]     ff_len;
   logic [2:0]      ff_hdr;
   logic [2:0]      cf_room;
   logic [11:0]     cf_rem;
   logic [2:0]      cf_n;
   logic [11:0]     cf_count;

   logic [3:0]      total;
   logic            emit_last;
   logic [2:0]      byte_sel;
   logic [7:0]      fc_fill;
   rsp_payload_type result;
   rsp_payload_type rsp_ff;
   logic            rsp_valid_ff;

   // Configuration writes; unlisted indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_mode_ff   <= 1'b0;
         cfg_own_ff    <= 8'h00;
         cfg_remote_ff <= 8'h00;
         cfg_full_ff   <= 1'b1;
         cfg_pad_ff    <= 8'h00;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ADDRESSING_MODE: cfg_mode_ff   <= csr_write_data[0];
            CSR_OWN_ADDRESS:     cfg_own_ff    <= csr_write_data;
            CSR_REMOTE_ADDRESS:  cfg_remote_ff <= csr_write_data;
            CSR_FULL_FRAME:      cfg_full_ff   <= csr_write_data[0];
            CSR_PAD_BYTE:        cfg_pad_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Header fields; in extended addressing everything shifts by one byte.
   assign off      = cfg_mode_ff;
   assign pci      = off ? req_payload.frame_byte1 : req_payload.frame_byte0;
   assign addr_bad = off && (req_payload.frame_byte0 != cfg_own_ff);
   assign sf_len   = pci[3:0];
   assign ff_len   = {pci[3:0], (off ? req_payload.frame_byte2 : req_payload.frame_byte1)};
   assign ff_hdr   = off ? 3'd5 : 3'd6;
   assign cf_room  = off ? 3'd6 : 3'd7;

   // Consecutive frame share of the remaining message.
   assign cf_rem   = (rx_ff.expected_length > rx_ff.received_count) ?
                     (rx_ff.expected_length - rx_ff.received_count) : 12'd0;
   assign cf_n     = (cf_rem < {9'd0, cf_room}) ? cf_rem[2:0] : cf_room;
   assign cf_count = rx_ff.received_count + {9'd0, cf_n};

   // Frame decode into a result plan and the next reception state.
   always_comb begin
      plan_in.nbytes         = 3'd0;
      plan_in.first          = 3'd0;
      plan_in.tail           = TAIL_ERROR;
      plan_in.error_code     = ERR_INVALID;
      plan_in.message_length = 12'd0;
      rx_in                  = '0;
      if (req_payload.command == CMD_TIMEOUT) begin
         plan_in.error_code = ERR_TIMEOUT;
      end else if (req_payload.frame_length == 4'd0) begin
         plan_in.error_code = ERR_INVALID;
      end else begin
         unique case (pci[7:4])
            PCI_SINGLE: begin
               if (addr_bad) begin
                  plan_in.error_code = ERR_WRONG_ADDR;
               end else if ((sf_len == 4'd0) || (sf_len > {1'b0, cf_room})) begin
                  plan_in.error_code = ERR_BAD_LENGTH;
               end else begin
                  plan_in.nbytes         = sf_len[2:0];
                  plan_in.first          = off ? 3'd2 : 3'd1;
                  plan_in.tail           = TAIL_DONE;
                  plan_in.message_length = {8'd0, sf_len};
               end
            end
            PCI_FIRST: begin
               // A first frame must be a full frame, with a length code of eight or more.
               if (!req_payload.frame_length[3]) begin
                  plan_in.error_code = ERR_INVALID;
               end else if (addr_bad) begin
                  plan_in.error_code = ERR_WRONG_ADDR;
               end else if (ff_len <= {9'd0, ff_hdr}) begin
                  plan_in.error_code = ERR_BAD_LENGTH;
               end else begin
                  plan_in.nbytes        = ff_hdr;
                  plan_in.first         = off ? 3'd3 : 3'd2;
                  plan_in.tail          = TAIL_FC;
                  rx_in.receiving       = 1'b1;
                  rx_in.expected_length = ff_len;
                  rx_in.received_count  = {9'd0, ff_hdr};
               end
            end
            PCI_CONSECUTIVE: begin
               if (!rx_ff.receiving) begin
                  plan_in.error_code = ERR_UNEXPECTED;
               end else begin
                  plan_in.nbytes = cf_n;
                  plan_in.first  = off ? 3'd2 : 3'd1;
                  if (cf_count >= rx_ff.expected_length) begin
                     plan_in.tail           = TAIL_DONE;
                     plan_in.message_length = rx_ff.expected_length;
                  end else begin
                     plan_in.tail          = TAIL_NONE;
                     rx_in.receiving       = 1'b1;
                     rx_in.expected_length = rx_ff.expected_length;
                     rx_in.received_count  = cf_count;
                  end
               end
            end
            default: plan_in.error_code = ERR_INVALID;
         endcase
      end
   end

   // Reception state follows each accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_ff <= '0;
      end else if (cmd.load) begin
         rx_ff <= rx_in;
      end
   end

   // Frame bytes and plan for the item in progress.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         plan_ff     <= plan_in;
         frame_ff[0] <= req_payload.frame_byte0;
         frame_ff[1] <= req_payload.frame_byte1;
         frame_ff[2] <= req_payload.frame_byte2;
         frame_ff[3] <= req_payload.frame_byte3;
         frame_ff[4] <= req_payload.frame_byte4;
         frame_ff[5] <= req_payload.frame_byte5;
         frame_ff[6] <= req_payload.frame_byte6;
         frame_ff[7] <= req_payload.frame_byte7;
      end
   end

   // Result counter within the item.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 4'd0;
      end else if (cmd.load) begin
         idx_ff <= 4'd0;
      end else if (cmd.emit) begin
         idx_ff <= idx_ff + 4'd1;
      end
   end

   assign total     = {1'b0, plan_ff.nbytes} + {3'd0, (plan_ff.tail != TAIL_NONE)};
   assign emit_last = (idx_ff == (total - 4'd1));
   assign byte_sel  = plan_ff.first + idx_ff[2:0];
   assign fc_fill   = cfg_full_ff ? cfg_pad_ff : 8'h00;

   // Current result: payload bytes first, then the closing result if any.
   always_comb begin
      result = '0;
      if (idx_ff < {1'b0, plan_ff.nbytes}) begin
         result.kind      = KIND_DATA;
         result.data_byte = frame_ff[byte_sel];
      end else begin
         case (plan_ff.tail)
            TAIL_NONE: ;
            TAIL_DONE: begin
               result.kind           = KIND_DONE;
               result.message_length = plan_ff.message_length;
            end
            TAIL_FC: begin
               result.kind      = KIND_FC;
               result.fc_length = cfg_full_ff ? FC_FULL_LEN : (off ? 4'd4 : 4'd3);
               if (off) begin
                  result.fc_byte0 = cfg_remote_ff;
                  result.fc_byte1 = FC_CTS;
                  result.fc_byte2 = 8'h00;
                  result.fc_byte3 = 8'h00;
               end else begin
                  result.fc_byte0 = FC_CTS;
                  result.fc_byte1 = 8'h00;
                  result.fc_byte2 = 8'h00;
                  result.fc_byte3 = fc_fill;
               end
            end
            TAIL_ERROR: begin
               result.kind       = KIND_ERROR;
               result.error_code = plan_ff.error_code;
            end
         endcase
      end
      result.last = emit_last;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_payload   = rsp_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;
   assign sts.emit_last = emit_last;

   // The result counter never runs past the item's result count.
   `ISOTP_ASSERT_IMPL(a_idx_in_range, cmd.emit, idx_ff < total)
   // While receiving, the message is never already complete.
   `ISOTP_ASSERT_IMPL(a_rx_incomplete, rx_ff.receiving,
      rx_ff.received_count < rx_ff.expected_length)
   // Leaving reception always clears the length and count.
   `ISOTP_ASSERT_IMPL(a_idle_cleared, !rx_ff.receiving,
      (rx_ff.expected_length == 12'd0) && (rx_ff.received_count == 12'd0))

endmodule

### dv/tb_isotp_receive_reassembler.sv
// ============================================================================
// ISO-TP receive reassembler testbench
// Drives received CAN frames and timeouts through the request channel, and
// predicts every payload byte, flow control frame, completion and error. The
// run starts with a table of protocol corner cases. Random phases follow:
// each programs a new register setting and sends mostly well-formed messages
// mixed with broken frames, while the channels idle and stall at random in most phases.
// ============================================================================
module tb_isotp_receive_reassembler;
   timeunit 1ns;
   timeprecision 1ps;

   import isotp_pkg::*;

   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_ITEMS    = 55;
   localparam int HOLD_OFF_CYCLES = 300;

   typedef enum logic {ROW_FRAME, ROW_CSR} row_kind_type;

   // One row of the directed table: a frame to send or a register to write.
   typedef struct {
      row_kind_type             kind;
      logic [CSR_INDEX_W-1:0]   csr_index;
      logic [CSR_DATA_W-1:0]    csr_value;
      req_payload_type          item;
      bit                       typed;
      rsp_payload_type          typed_result;
   } stimulus_row_type;

   logic clock;
   logic reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   isotp_req_if req_chan ();
   isotp_rsp_if rsp_chan ();

   isotp_receive_reassembler uut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Register copies and reception state of the predictor.
   logic       cfg_extended       = 1'b0;
   logic [7:0] cfg_own_address    = 8'h00;
   logic [7:0] cfg_remote_address = 8'h00;
   logic       cfg_full_frame     = 1'b1;
   logic [7:0] cfg_pad_byte       = 8'h00;
   logic        rx_active = 1'b0;
   logic [11:0] rx_total  = 12'd0;
   logic [11:0] rx_count  = 12'd0;

   rsp_payload_type  step_results[$];
   rsp_payload_type  pending_results[$];
   stimulus_row_type directed_rows[$];

   int  mismatches = 0;
   int  items_sent = 0;
   int  cycle_count = 0;
   bit  req_steady = 1'b0;
   bit  rsp_steady = 1'b0;
   int  rsp_hold_request = 0;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   // Idle length: mostly none or short, now and then a long one.
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic void clear_reception();
      rx_active = 1'b0;
      rx_total  = 12'd0;
      rx_count  = 12'd0;
   endfunction

   function automatic rsp_payload_type error_result(logic [2:0] code);
      rsp_payload_type r;
      r = '0;
      r.kind       = KIND_ERROR;
      r.error_code = code;
      r.last       = 1'b1;
      return r;
   endfunction

   function automatic void push_error(logic [2:0] code);
      step_results.push_back(error_result(code));
      clear_reception();
   endfunction

   function automatic void push_data(logic [7:0] value);
      rsp_payload_type r;
      r = '0;
      r.kind      = KIND_DATA;
      r.data_byte = value;
      step_results.push_back(r);
   endfunction

   function automatic void push_done(logic [11:0] length);
      rsp_payload_type r;
      r = '0;
      r.kind           = KIND_DONE;
      r.message_length = length;
      step_results.push_back(r);
      clear_reception();
   endfunction

   // Works out the results of one frame and advances the reception state.
   function automatic void predict_results(input req_payload_type item);
      logic [7:0]      fb [8];
      logic [7:0]      pci;
      logic [7:0]      fill;
      logic [11:0]     ff_len;
      rsp_payload_type fc;
      int              flen, off, sf_len, rem, n;
      step_results.delete();
      fb = '{item.frame_byte0, item.frame_byte1, item.frame_byte2, item.frame_byte3,
             item.frame_byte4, item.frame_byte5, item.frame_byte6, item.frame_byte7};
      flen = (item.frame_length > 4'd8) ? 8 : int'(item.frame_length);
      off  = cfg_extended ? 1 : 0;
      pci  = fb[off];
      if (item.command == CMD_TIMEOUT) begin
         push_error(ERR_TIMEOUT);
      end else if (flen == 0) begin
         push_error(ERR_INVALID);
      end else if (pci[7:4] == PCI_SINGLE) begin
         sf_len = pci[3:0];
         if (off == 1 && fb[0] != cfg_own_address) begin
            push_error(ERR_WRONG_ADDR);
         end else if (sf_len == 0 || sf_len > 7 - off) begin
            push_error(ERR_BAD_LENGTH);
         end else begin
            for (int i = 0; i < sf_len; i++) push_data(fb[1 + off + i]);
            push_done(12'(sf_len));
         end
      end else if (pci[7:4] == PCI_FIRST && flen == 8) begin
         ff_len = {pci[3:0], fb[off + 1]};
         if (off == 1 && fb[0] != cfg_own_address) begin
            push_error(ERR_WRONG_ADDR);
         end else if (int'(ff_len) <= 6 - off) begin
            push_error(ERR_BAD_LENGTH);
         end else begin
            for (int i = off + 2; i < 8; i++) push_data(fb[i]);
            // Flow control: continue to send, block size 0, separation time 0.
            fc = '0;
            fc.kind = KIND_FC;
            fill = cfg_full_frame ? cfg_pad_byte : 8'h00;
            fc.fc_length = cfg_full_frame ? FC_FULL_LEN : 4'(3 + off);
            if (off == 1) begin
               fc.fc_byte0 = cfg_remote_address;
               fc.fc_byte1 = FC_CTS;
            end else begin
               fc.fc_byte0 = FC_CTS;
               fc.fc_byte3 = fill;
            end
            step_results.push_back(fc);
            rx_active = 1'b1;
            rx_total  = ff_len;
            rx_count  = 12'(6 - off);
         end
      end else if (pci[7:4] == PCI_CONSECUTIVE) begin
         if (!rx_active) begin
            push_error(ERR_UNEXPECTED);
         end else begin
            rem = (rx_total > rx_count) ? int'(rx_total) - int'(rx_count) : 0;
            n = (rem < 7 - off) ? rem : 7 - off;
            for (int i = 0; i < n; i++) push_data(fb[1 + off + i]);
            rx_count = rx_count + 12'(n);
            if (rx_count >= rx_total) push_done(rx_total);
         end
      end else begin
         push_error(ERR_INVALID);
      end
      step_results[step_results.size() - 1].last = 1'b1;
   endfunction

   function automatic void apply_register(logic [CSR_INDEX_W-1:0] index,
                                          logic [CSR_DATA_W-1:0] value);
      case (index)
         CSR_ADDRESSING_MODE: cfg_extended       = value[0];
         CSR_OWN_ADDRESS:     cfg_own_address    = value;
         CSR_REMOTE_ADDRESS:  cfg_remote_address = value;
         CSR_FULL_FRAME:      cfg_full_frame     = value[0];
         CSR_PAD_BYTE:        cfg_pad_byte       = value;
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Directed table rows
   // ---------------------------------------------------------------------
   function automatic stimulus_row_type frame_row(logic command, logic [3:0] length,
                                                  logic [63:0] data);
      stimulus_row_type row;
      row.kind         = ROW_FRAME;
      row.csr_index    = '0;
      row.csr_value    = '0;
      row.item         = {command, length, data};
      row.typed        = 1'b0;
      row.typed_result = '0;
      return row;
   endfunction

   function automatic stimulus_row_type error_row(logic command, logic [3:0] length,
                                                  logic [63:0] data, logic [2:0] code);
      stimulus_row_type row;
      row = frame_row(command, length, data);
      row.typed        = 1'b1;
      row.typed_result = error_result(code);
      return row;
   endfunction

   function automatic stimulus_row_type csr_row(logic [CSR_INDEX_W-1:0] index,
                                                logic [CSR_DATA_W-1:0] value);
      stimulus_row_type row;
      row = frame_row(CMD_FRAME, 4'd0, 64'd0);
      row.kind      = ROW_CSR;
      row.csr_index = index;
      row.csr_value = value;
      return row;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Offers one item after a random gap, none in steady mode, and records its expected
   // results once it is taken. Called right after a rising edge.
   task automatic send_frame(input req_payload_type item, input bit typed = 1'b0,
                             input rsp_payload_type typed_result = '0);
      int gap;
      gap = req_steady ? 0 : idle_length();
      csr_write_enable <= 1'b0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= item;
      do @(posedge clock); while (!req_chan.ready);
      predict_results(item);
      if (typed) step_results = '{typed_result};
      pending_results = {pending_results, step_results};
      items_sent++;
   endtask

   // Stops offering and waits until every expected result has come.
   task automatic wait_idle();
      req_chan.valid   <= 1'b0;
      csr_write_enable <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      apply_register(index, value);
   endtask

   // A frame with random content, its control byte placed for the current
   // addressing mode. In extended mode the address byte is mostly our own.
   function automatic req_payload_type protocol_frame(logic [7:0] pci, logic [7:0] second,
                                                      logic [3:0] length);
      req_payload_type f;
      f = {CMD_FRAME, length, $urandom, $urandom};
      if (cfg_extended) begin
         f.frame_byte0 = ($urandom_range(0, 11) == 0) ? 8'($urandom) : cfg_own_address;
         f.frame_byte1 = pci;
         f.frame_byte2 = second;
      end else begin
         f.frame_byte0 = pci;
         f.frame_byte1 = second;
      end
      return f;
   endfunction

   // Broken or unexpected frames and timeouts.
   task automatic send_noise();
      req_payload_type f;
      case ($urandom_range(0, 5))
         0: begin
            f = {CMD_TIMEOUT, 4'($urandom), $urandom, $urandom};
         end
         1: begin
            f = {CMD_FRAME, 4'($urandom), $urandom, $urandom};
         end
         2: f = protocol_frame(8'($urandom_range(8'h30, 8'hFF)), 8'($urandom),
                               4'($urandom));
         3: f = protocol_frame({PCI_SINGLE, 4'($urandom)}, 8'($urandom),
                               4'($urandom_range(1, 15)));
         4: f = protocol_frame({PCI_FIRST, 4'($urandom)}, 8'($urandom), 4'($urandom));
         default: f = protocol_frame({PCI_CONSECUTIVE, 4'($urandom)}, 8'($urandom),
                                     4'($urandom));
      endcase
      send_frame(f);
   endtask

   // One message: a segmented transfer, a single frame, or noise.
   task automatic send_message();
      int off, choice, total, remaining, cf_budget, seq;
      off = cfg_extended ? 1 : 0;
      choice = $urandom_range(0, 99);
      if (choice < 50) begin
         // Segmented transfer; very long ones are cut off after a few frames.
         if ($urandom_range(0, 11) == 0) begin
            total     = $urandom_range(301, 4095);
            cf_budget = $urandom_range(0, 3);
         end else begin
            total     = $urandom_range(7 - off, ($urandom_range(0, 4) == 0) ? 120 : 30);
            cf_budget = 1000;
         end
         send_frame(protocol_frame({PCI_FIRST, 4'(total >> 8)}, 8'(total), 4'd8));
         remaining = total - (6 - off);
         seq = 1;
         while (remaining > 0) begin
            if (cf_budget == 0 || $urandom_range(0, 39) == 0) begin
               send_noise();
               break;
            end
            send_frame(protocol_frame({PCI_CONSECUTIVE, 4'(seq)}, 8'($urandom),
                                      ($urandom_range(0, 4) == 0) ?
                                      4'($urandom_range(1, 15)) : 4'd8));
            remaining -= 7 - off;
            seq++;
            cf_budget--;
         end
      end else if (choice < 75) begin
         total = $urandom_range(1, 7 - off);
         send_frame(protocol_frame({PCI_SINGLE, 4'(total)}, 8'($urandom),
                                   ($urandom_range(0, 3) == 0) ?
                                   4'($urandom_range(1, 15)) : 4'(total + 1 + off)));
      end else begin
         send_noise();
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------
   // Ready pattern: random stalls and runs, a steady mode, and a long
   // hold-off on request.
   initial begin : rsp_ready_driver
      int stall_left, run_left;
      stall_left = 0;
      run_left   = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request > 0) begin
            stall_left       = rsp_hold_request;
            rsp_hold_request = 0;
            run_left         = 0;
         end
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else if (rsp_steady || run_left > 0) begin
            rsp_chan.ready <= 1'b1;
            if (run_left > 0) run_left--;
         end else begin
            stall_left = idle_length();
            run_left   = $urandom_range(1, 12);
            rsp_chan.ready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
            else run_left--;
         end
      end
   end

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   // Each result taken is checked against the oldest expectation.
   always @(posedge clock) begin : rsp_checker
      rsp_payload_type want;
      rsp_payload_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.payload;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0d",
                     $time, got.kind);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("data_byte", want.data_byte, got.data_byte);
            compare_field("fc_length", want.fc_length, got.fc_length);
            compare_field("fc_byte0", want.fc_byte0, got.fc_byte0);
            compare_field("fc_byte1", want.fc_byte1, got.fc_byte1);
            compare_field("fc_byte2", want.fc_byte2, got.fc_byte2);
            compare_field("fc_byte3", want.fc_byte3, got.fc_byte3);
            compare_field("message_length", want.message_length, got.message_length);
            compare_field("error_code", want.error_code, got.error_code);
            compare_field("last", want.last, got.last);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : main_sequence
      int phase_start;
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_write_data   <= '0;

      // Normal addressing with the reset register values.
      directed_rows.push_back(error_row(CMD_TIMEOUT, 4'd0, 64'h0, ERR_TIMEOUT));
      directed_rows.push_back(error_row(CMD_FRAME, 4'd0, '1, ERR_INVALID));
      directed_rows.push_back(error_row(CMD_FRAME, 4'd8, 64'h21_11_22_33_44_55_66_77,
                                        ERR_UNEXPECTED));
      directed_rows.push_back(error_row(CMD_FRAME, 4'd1, 64'h00_FF_FF_FF_FF_FF_FF_FF,
                                        ERR_BAD_LENGTH));
      directed_rows.push_back(frame_row(CMD_FRAME, 4'd8, 64'h07_11_22_33_44_55_66_77));
      directed_rows.push_back(error_row(CMD_FRAME, 4'd8, 64'h08_11_22_33_44_55_66_77,
                                        ERR_BAD_LENGTH));
      directed_rows.push_back(frame_row(CMD_FRAME, 4'd15, 64'h01_FF_00_00_00_00_00_00));
      directed_rows.push_back(frame_row(CMD_FRAME, 4'd1, 64'h05_A1_A2_A3_A4_A5_00_00));
      directed_rows.push_back(error_row(CMD_FRAME, 4'd8, 64'h10_06_01_02_03_04_05_06,
                                        ERR_BAD_LENGTH));
      directed_rows.push_back(error_row(CMD_FRAME, 4'd7, 64'h10_20_01_02_03_04_05_06,
                                        ERR_INVALID));
      directed_rows.push_back(frame_row(CMD_FRAME, 4'd8, 64'h1F_FF_01_02_03_04_05_06));
      // A first frame while receiving restarts the count.
      directed_rows.push_back(frame_row(CMD_FRAME, 4'd8, 64'h10_0A_C1_C2_C3_C4_C5_C6));
      directed_rows.push_back(frame_row(CMD_FRAME, 4'd8, 64'h21_D1_D2_D3_D4_D5_D6_D7));
      // A single frame abandons the reception in progress.
      directed_rows.push_back(frame_row(CMD_FRAME, 4'd8, 64'h10_14_E0_E1_E2_E3_E4_E5));
      directed_rows.push_back(frame_row(CMD_FRAME, 4'd8, 64'h2F_00_FF_00_FF_00_FF_00));
      directed_rows.push_back(frame_row(CMD_FRAME, 4'd3, 64'h02_E1_E2_00_00_00_00_00));
      // A timeout while receiving.
      directed_rows.push_back(frame_row(CMD_FRAME, 4'd8, 64'h10_08_01_02_03_04_05_06));
      directed_rows.push_back(error_row(CMD_TIMEOUT, 4'd8, 64'h21_00_00_00_00_00_00_00,
                                        ERR_TIMEOUT));
      directed_rows.push_back(error_row(CMD_FRAME, 4'd8, 64'h30_00_00_00_00_00_00_00,
                                        ERR_INVALID));
      directed_rows.push_back(error_row(CMD_FRAME, 4'd8, 64'hF0_FF_FF_FF_FF_FF_FF_FF,
                                        ERR_INVALID));
      // Extended addressing, unpadded flow control.
      directed_rows.push_back(csr_row(CSR_ADDRESSING_MODE, 8'd1));
      directed_rows.push_back(csr_row(CSR_OWN_ADDRESS, 8'h7E));
      directed_rows.push_back(csr_row(CSR_REMOTE_ADDRESS, 8'hF1));
      directed_rows.push_back(csr_row(CSR_PAD_BYTE, 8'hA5));
      directed_rows.push_back(csr_row(CSR_FULL_FRAME, 8'd0));
      directed_rows.push_back(frame_row(CMD_FRAME, 4'd8, 64'h7E_06_B1_B2_B3_B4_B5_B6));
      directed_rows.push_back(error_row(CMD_FRAME, 4'd8, 64'h7D_03_B1_B2_B3_B4_B5_B6,
                                        ERR_WRONG_ADDR));
      directed_rows.push_back(error_row(CMD_FRAME, 4'd8, 64'h7E_07_B1_B2_B3_B4_B5_B6,
                                        ERR_BAD_LENGTH));
      directed_rows.push_back(error_row(CMD_FRAME, 4'd8, 64'h00_10_40_01_02_03_04_05,
                                        ERR_WRONG_ADDR));
      directed_rows.push_back(error_row(CMD_FRAME, 4'd8, 64'h7E_10_05_01_02_03_04_05,
                                        ERR_BAD_LENGTH));
      // Consecutive frames: address byte and sequence number are ignored.
      directed_rows.push_back(frame_row(CMD_FRAME, 4'd8, 64'h7E_10_0D_01_02_03_04_05));
      directed_rows.push_back(frame_row(CMD_FRAME, 4'd8, 64'h55_25_11_12_13_14_15_16));
      directed_rows.push_back(frame_row(CMD_FRAME, 4'd4, 64'h7E_2A_21_22_00_00_00_00));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part.
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CSR) begin
            wait_idle();
            write_register(directed_rows[r].csr_index, directed_rows[r].csr_value);
         end else begin
            send_frame(directed_rows[r].item, directed_rows[r].typed,
                       directed_rows[r].typed_result);
         end
      end

      // Random phases, each with its own register setting.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_idle();
         write_register(CSR_ADDRESSING_MODE, 8'(phase % 2));
         write_register(CSR_OWN_ADDRESS, (phase == 1) ? 8'hFF :
                                         (phase == 3) ? 8'h00 : 8'($urandom));
         write_register(CSR_REMOTE_ADDRESS, (phase == 1) ? 8'h00 :
                                            (phase == 3) ? 8'hFF : 8'($urandom));
         write_register(CSR_FULL_FRAME, 8'((phase / 2) % 2));
         write_register(CSR_PAD_BYTE, (phase == 0) ? 8'hFF :
                                      (phase == 2) ? 8'h00 : 8'($urandom));
         // Back-pressure: the receiver holds off while frames keep coming.
         if (phase == 2) begin
            req_steady       = 1'b1;
            rsp_hold_request = HOLD_OFF_CYCLES;
         end
         // No idling on either side.
         if (phase == 5) begin
            req_steady = 1'b1;
            rsp_steady = 1'b1;
         end
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) send_message();
         req_steady = 1'b0;
         rsp_steady = 1'b0;
      end

      // Drain and let any stray result show up.
      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatches == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

### isotp_receive_reassembler.f
+incdir+sv
sv/isotp_pkg.sv
sv/isotp_req_if.sv
sv/isotp_rsp_if.sv
sv/isotp_ctrl.sv
sv/isotp_dpath.sv
sv/isotp_receive_reassembler.sv
dv/tb_isotp_receive_reassembler.sv
